@@ src/srtf_pkg.sv @@
// srtf_pkg: shared widths, result status codes and the control struct
// passed from the scheduler sequencer to the shared minimum/compare unit.
// No dependencies.
package srtf_pkg;

  // fixed field widths
  localparam int DUR_W    = 16;
  localparam int STATUS_W = 2;
  localparam int QCOUNT_W = 5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RUN    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd3;

  // control for the shared compare unit
  typedef struct packed {
    logic sample;       // take one queue entry into the running minimum
    logic first;        // entry is the head of the queue, load unconditionally
    logic against_cur;  // compare the best entry with the running task
  } min_ctl_t;

endpackage

@@ src/srtf_if.sv @@
// srtf_req_if / srtf_rsp_if: valid/ready channels of the scheduler
// depends on srtf_pkg for the fixed field widths
interface srtf_req_if #(
  parameter int ID_W = 8
);
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ID_W-1:0]          task_id;
  logic [srtf_pkg::DUR_W-1:0] task_duration;

  modport source (output valid, kind, task_id, task_duration, input ready);
  modport sink   (input valid, kind, task_id, task_duration, output ready);
endinterface

interface srtf_rsp_if #(
  parameter int ID_W = 8
);
  logic                          valid;
  logic                          ready;
  logic [srtf_pkg::STATUS_W-1:0] status;
  logic [ID_W-1:0]               running_id;
  logic [srtf_pkg::DUR_W-1:0]    running_remaining;
  logic                          finished;
  logic                          preempted;
  logic [ID_W-1:0]               preempted_id;
  logic [srtf_pkg::QCOUNT_W-1:0] queue_count;

  modport source (output valid, status, running_id, running_remaining, finished,
                  preempted, preempted_id, queue_count, input ready);
  modport sink   (input valid, status, running_id, running_remaining, finished,
                  preempted, preempted_id, queue_count, output ready);
endinterface

@@ src/srtf_min_unit.sv @@
// srtf_min_unit: shared comparator and running-minimum registers
// used for the queue scan and for the preemption test; depends on srtf_pkg
module srtf_min_unit #(
  parameter int IDX_W = 4,
  parameter int ID_W  = 8
) (
  input  logic                       clk_i,
  input  srtf_pkg::min_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [ID_W-1:0]            id_i,
  input  logic [srtf_pkg::DUR_W-1:0] rem_i,
  input  logic [srtf_pkg::DUR_W-1:0] cur_rem_i,
  output logic [IDX_W-1:0]           best_idx_o,
  output logic [ID_W-1:0]            best_id_o,
  output logic [srtf_pkg::DUR_W-1:0] best_rem_o,
  output logic                       lt_o
);
  import srtf_pkg::*;

  logic [IDX_W-1:0] best_idx_q;
  logic [ID_W-1:0]  best_id_q;
  logic [DUR_W-1:0] best_rem_q;
  logic [DUR_W-1:0] op_l;
  logic [DUR_W-1:0] op_r;
  logic             load;

  // one less-than comparator, operands steered by the sequencer
  assign op_l = ctl_i.against_cur ? best_rem_q : rem_i;
  assign op_r = ctl_i.against_cur ? cur_rem_i  : best_rem_q;
  assign lt_o = op_l < op_r;

  // strict compare keeps the earliest position on a tie
  assign load = ctl_i.sample && (ctl_i.first || lt_o);

  always_ff @(posedge clk_i) begin
    if (load) begin
      best_idx_q <= idx_i;
      best_id_q  <= id_i;
      best_rem_q <= rem_i;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_id_o  = best_id_q;
  assign best_rem_o = best_rem_q;

endmodule

@@ src/srtf_preemptive_scheduler.sv @@
// srtf_preemptive_scheduler: shortest-remaining-time-first scheduler top level
// holds the ready queue memory, sequencer and result register; depends on
// srtf_pkg, srtf_req_if, srtf_rsp_if and srtf_min_unit
// arrival: appended to the queue unless full, then the result is registered
// tick: scan the waiting tasks for the shortest, compare it with the running task;
// if taken, compact the queue, requeue any preempted task; empty queue skips scan
// request ready only while the sequencer is idle; a stalled result holds it off
// reset (async, active low) clears count and running task; queue unwritten
module srtf_preemptive_scheduler #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srtf_req_if.sink   req_i,
  srtf_rsp_if.source rsp_o
);
  import srtf_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_RUN    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  typedef struct packed {
    logic [TASK_ID_BITS-1:0] id;
    logic [DUR_W-1:0]        rem;
  } entry_t;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q;
  logic                    cur_valid_q;
  logic [TASK_ID_BITS-1:0] cur_id_q;
  logic [DUR_W-1:0]        cur_rem_q;
  logic                    pre_q;
  logic [TASK_ID_BITS-1:0] pre_id_q;
  logic [DUR_W-1:0]        pre_rem_q;

  logic [STATUS_W-1:0]     res_status_q;
  logic [TASK_ID_BITS-1:0] res_id_q;
  logic [DUR_W-1:0]        res_rem_q;
  logic                    res_fin_q;
  logic                    res_pre_q;
  logic [TASK_ID_BITS-1:0] res_pre_id_q;

  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [TASK_ID_BITS-1:0] out_id_q;
  logic [DUR_W-1:0]        out_rem_q;
  logic                    out_fin_q;
  logic                    out_pre_q;
  logic [TASK_ID_BITS-1:0] out_pre_id_q;
  logic [QCOUNT_W-1:0]     out_count_q;

  entry_t                  mem [QUEUE_DEPTH];
  entry_t                  rd_data_q;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        rd_idx_q;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  entry_t                  mem_wd;

  min_ctl_t                min_ctl;
  logic [IDX_W-1:0]        best_idx;
  logic [TASK_ID_BITS-1:0] best_id;
  logic [DUR_W-1:0]        best_rem;
  logic                    min_lt;

  logic                    req_take;
  logic                    full;
  logic                    idx_last;
  logic                    best_last;
  logic                    take;
  logic                    slot_free;
  logic [DUR_W-1:0]        dec_rem;

  // shared compare unit
  srtf_min_unit #(
    .IDX_W (IDX_W),
    .ID_W  (TASK_ID_BITS)
  ) u_min (
    .clk_i      (clk_i),
    .ctl_i      (min_ctl),
    .idx_i      (rd_idx_q),
    .id_i       (rd_data_q.id),
    .rem_i      (rd_data_q.rem),
    .cur_rem_i  (cur_rem_q),
    .best_idx_o (best_idx),
    .best_id_o  (best_id),
    .best_rem_o (best_rem),
    .lt_o       (min_lt)
  );

  // status terms
  assign req_i.ready = (state_q == S_IDLE);
  assign req_take    = req_i.valid && req_i.ready;
  assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
  assign idx_last    = (CNT_W'(rd_idx_q) == count_q - CNT_W'(1));
  assign best_last   = (CNT_W'(best_idx) == count_q - CNT_W'(1));
  assign take        = !cur_valid_q || min_lt;
  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign dec_rem     = (cur_rem_q == '0) ? '0 : cur_rem_q - DUR_W'(1);

  // sequencer and queue port control
  always_comb begin
    state_d = state_q;
    rd_addr = '0;
    min_ctl = '0;
    mem_we  = 1'b0;
    mem_wa  = '0;
    mem_wd  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_take) begin
          if (!req_i.kind) begin
            if (!full) begin
              mem_we = 1'b1;
              mem_wa = count_q[IDX_W-1:0];
              mem_wd = '{id: req_i.task_id, rem: req_i.task_duration};
            end
            state_d = S_DONE;
          end else begin
            state_d = (count_q == '0) ? S_RUN : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        min_ctl.sample = 1'b1;
        min_ctl.first  = (rd_idx_q == '0);
        if (idx_last) begin
          state_d = S_DECIDE;
        end else begin
          rd_addr = rd_idx_q + IDX_W'(1);
        end
      end
      S_DECIDE: begin
        min_ctl.against_cur = 1'b1;
        if (take) begin
          if (best_last) begin
            state_d = S_APPEND;
          end else begin
            rd_addr = best_idx + IDX_W'(1);
            state_d = S_SHIFT;
          end
        end else begin
          state_d = S_RUN;
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = rd_idx_q - IDX_W'(1);
        mem_wd = rd_data_q;
        if (idx_last) begin
          state_d = S_APPEND;
        end else begin
          rd_addr = rd_idx_q + IDX_W'(1);
        end
      end
      S_APPEND: begin
        if (pre_q) begin
          mem_we = 1'b1;
          mem_wa = IDX_W'(count_q - CNT_W'(1));
          mem_wd = '{id: pre_id_q, rem: pre_rem_q};
        end
        state_d = S_RUN;
      end
      S_RUN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ready queue memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_idx_q    <= '0;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
      cur_rem_q   <= '0;
      pre_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_addr;
      if (state_q == S_IDLE && req_take) begin
        if (!req_i.kind && !full) begin
          count_q <= count_q + CNT_W'(1);
        end
        pre_q <= 1'b0;
      end
      if (state_q == S_DECIDE && take) begin
        pre_q       <= cur_valid_q;
        cur_valid_q <= 1'b1;
        cur_id_q    <= best_id;
        cur_rem_q   <= best_rem;
      end
      if (state_q == S_APPEND && !pre_q) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (state_q == S_RUN && cur_valid_q) begin
        cur_rem_q <= dec_rem;
        if (dec_rem == '0) begin
          cur_valid_q <= 1'b0;
          cur_id_q    <= '0;
        end
      end
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_take && !req_i.kind) begin
      res_status_q <= full ? ST_DROP : ST_ACCEPT;
      res_id_q     <= '0;
      res_rem_q    <= '0;
      res_fin_q    <= 1'b0;
      res_pre_q    <= 1'b0;
      res_pre_id_q <= '0;
    end
    if (state_q == S_DECIDE && take) begin
      pre_id_q  <= cur_id_q;
      pre_rem_q <= cur_rem_q;
    end
    if (state_q == S_RUN) begin
      res_pre_q    <= pre_q;
      res_pre_id_q <= pre_q ? pre_id_q : '0;
      if (cur_valid_q) begin
        res_status_q <= ST_RUN;
        res_id_q     <= cur_id_q;
        res_rem_q    <= dec_rem;
        res_fin_q    <= (dec_rem == '0);
      end else begin
        res_status_q <= ST_IDLE;
        res_id_q     <= '0;
        res_rem_q    <= '0;
        res_fin_q    <= 1'b0;
      end
    end
    if (state_q == S_DONE && slot_free) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_rem_q    <= res_rem_q;
      out_fin_q    <= res_fin_q;
      out_pre_q    <= res_pre_q;
      out_pre_id_q <= res_pre_id_q;
      out_count_q  <= QCOUNT_W'(count_q);
    end
  end

  // response channel
  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.status            = out_status_q;
  assign rsp_o.running_id        = out_id_q;
  assign rsp_o.running_remaining = out_rem_q;
  assign rsp_o.finished          = out_fin_q;
  assign rsp_o.preempted         = out_pre_q;
  assign rsp_o.preempted_id      = out_pre_id_q;
  assign rsp_o.queue_count       = out_count_q;

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("ready queue count beyond depth");

  // compaction only moves entries that lie inside the queue
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> (rd_idx_q != '0) && (CNT_W'(rd_idx_q) < count_q))
    else $error("compaction read outside the queue");

  // the scan sees a fixed queue length
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |=> $stable(count_q))
    else $error("queue count changed during scan");

  // preemption is only reported on a tick that ran a task
  a_pre_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.preempted |-> rsp_o.status == ST_RUN)
    else $error("preemption flagged without a running task");

  // a finished task leaves no running task behind
  a_fin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN && cur_valid_q && dec_rem == '0 |=> !cur_valid_q)
    else $error("finished task still marked running");
`endif

endmodule

@@ verif/srtf_tb_pkg.sv @@
// srtf_tb_pkg: request kind codes shared by the scheduler checker and stimulus
// no dependencies
`timescale 1ns / 100ps
package srtf_tb_pkg;

  // what one request asks of the scheduler
  typedef enum logic {
    REQ_ARRIVAL = 1'b0,
    REQ_TICK    = 1'b1
  } req_kind_e;

endpackage

@@ verif/srtf_schedule_checker.sv @@
// srtf_schedule_checker: watches the scheduler request and result channels,
// predicts each result from its own copy of the ready queue and running task
// depends on srtf_pkg, srtf_tb_pkg, srtf_req_if and srtf_rsp_if
`timescale 1ns / 100ps
module srtf_schedule_checker #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srtf_req_if         req_i,
  srtf_rsp_if         rsp_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned outstanding_o
);
  import srtf_pkg::*;
  import srtf_tb_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [TASK_ID_BITS-1:0] running_id;
    logic [DUR_W-1:0]        running_remaining;
    logic                    finished;
    logic                    preempted;
    logic [TASK_ID_BITS-1:0] preempted_id;
    logic [QCOUNT_W-1:0]     queue_count;
  } sched_result_t;

  // predicted scheduler state
  logic [TASK_ID_BITS-1:0] wait_id  [QUEUE_DEPTH];
  logic [DUR_W-1:0]        wait_rem [QUEUE_DEPTH];
  int unsigned             wait_cnt;
  bit                      run_valid;
  logic [TASK_ID_BITS-1:0] run_id;
  logic [DUR_W-1:0]        run_rem;

  sched_result_t expected_q[$];
  sched_result_t want_res;

  // append at the tail of the ready queue
  function automatic void push_waiting(input logic [TASK_ID_BITS-1:0] id,
                                       input logic [DUR_W-1:0] rem);
    if (wait_cnt < QUEUE_DEPTH) begin
      wait_id[wait_cnt]  = id;
      wait_rem[wait_cnt] = rem;
      wait_cnt++;
    end
  endfunction

  // take one entry out and close the gap
  function automatic void drop_waiting(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < wait_cnt; i++) begin
      wait_id[i]  = wait_id[i + 1];
      wait_rem[i] = wait_rem[i + 1];
    end
    wait_cnt--;
  endfunction

  // queue a predicted result behind the ones still pending
  function automatic void store_expected(input sched_result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  // one request through the scheduler, returns the result it should give
  function automatic sched_result_t predict_step(input logic kind,
                                                 input logic [TASK_ID_BITS-1:0] id,
                                                 input logic [DUR_W-1:0] dur);
    sched_result_t r;
    int unsigned best;
    logic [TASK_ID_BITS-1:0] best_id;
    logic [DUR_W-1:0] best_rem;
    r = '0;
    if (kind == REQ_ARRIVAL) begin
      if (wait_cnt >= QUEUE_DEPTH) begin
        r.status = ST_DROP;
      end else begin
        push_waiting(id, dur);
        r.status = ST_ACCEPT;
      end
    end else begin
      if (wait_cnt > 0) begin
        // shortest remaining, earliest position wins a tie
        best = 0;
        for (int unsigned i = 1; i < wait_cnt; i++) begin
          if (wait_rem[i] < wait_rem[best]) best = i;
        end
        best_id  = wait_id[best];
        best_rem = wait_rem[best];
        if (!run_valid) begin
          drop_waiting(best);
          run_valid = 1'b1;
          run_id    = best_id;
          run_rem   = best_rem;
        end else if (best_rem < run_rem) begin
          drop_waiting(best);
          push_waiting(run_id, run_rem);
          r.preempted    = 1'b1;
          r.preempted_id = run_id;
          run_id         = best_id;
          run_rem        = best_rem;
        end
      end
      if (run_valid) begin
        // saturating decrement, zero means done
        if (run_rem > 0) run_rem--;
        r.running_id        = run_id;
        r.running_remaining = run_rem;
        if (run_rem == 0) begin
          r.finished = 1'b1;
          run_valid  = 1'b0;
          run_id     = '0;
        end
        r.status = ST_RUN;
      end else begin
        r.status = ST_IDLE;
      end
    end
    r.queue_count = QCOUNT_W'(wait_cnt);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_cnt_o++;
    end
  endtask

  // results are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_cnt       = 0;
      run_valid      = 1'b0;
      run_id         = '0;
      run_rem        = '0;
      expected_q.delete();
      mismatch_cnt_o = 0;
      outstanding_o  = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got status %0d",
                   $time, rsp_i.status);
          mismatch_cnt_o++;
        end else begin
          want_res = expected_q.pop_front();
          compare_field("status", want_res.status, rsp_i.status);
          compare_field("running_id", want_res.running_id, rsp_i.running_id);
          compare_field("running_remaining", want_res.running_remaining,
                        rsp_i.running_remaining);
          compare_field("finished", want_res.finished, rsp_i.finished);
          compare_field("preempted", want_res.preempted, rsp_i.preempted);
          compare_field("preempted_id", want_res.preempted_id, rsp_i.preempted_id);
          compare_field("queue_count", want_res.queue_count, rsp_i.queue_count);
        end
      end
      if (req_i.valid && req_i.ready) begin
        store_expected(predict_step(req_i.kind, req_i.task_id, req_i.task_duration));
      end
      outstanding_o = expected_q.size();
    end
  end

endmodule

@@ verif/tb_srtf_preemptive_scheduler.sv @@
// tb_srtf_preemptive_scheduler: directed and random arrivals and ticks with
// random idling on both channels; depends on the scheduler, its interfaces and
// srtf_schedule_checker, which does all prediction and comparison
`timescale 1ns / 100ps
module tb_srtf_preemptive_scheduler;
  import srtf_pkg::*;
  import srtf_tb_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned outstanding;

  srtf_req_if #(.ID_W(TASK_ID_BITS)) req_if ();
  srtf_rsp_if #(.ID_W(TASK_ID_BITS)) rsp_if ();

  srtf_preemptive_scheduler #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  srtf_schedule_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .mismatch_cnt_o(mismatches),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // short jobs dominate so tasks finish and preempt often
  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return DUR_W'($urandom_range(1, 6));
    if (r < 80) return DUR_W'($urandom_range(7, 300));
    if (r < 95) return DUR_W'($urandom_range(1, 65535));
    if (r < 98) return '1;
    return '0;
  endfunction

  // hold the request until taken, then idle for the given gap
  task automatic send_request(input req_kind_e kind, input int unsigned id,
                              input logic [DUR_W-1:0] dur, input int unsigned gap);
    req_if.valid         <= 1'b1;
    req_if.kind          <= kind;
    req_if.task_id       <= TASK_ID_BITS'(id);
    req_if.task_duration <= dur;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending until every result is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
  endtask

  // result side back-pressure: long open stretches and random stalls
  initial begin
    int unsigned open_len;
    int unsigned stall_len;
    rsp_if.ready = 1'b0;
    forever begin
      open_len = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      rsp_if.ready <= 1'b1;
      repeat (open_len) @(posedge clk_i);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned arrive_pct;
    bit          steady;
    req_kind_e   kind;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.kind          = REQ_ARRIVAL;
    req_if.task_id       = '0;
    req_if.task_duration = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, extremes, finish, preemption, tie, zero duration
    send_request(REQ_TICK, 8'h00, 16'h0000, pick_gap());
    send_request(REQ_ARRIVAL, 8'hFF, 16'hFFFF, pick_gap());
    send_request(REQ_ARRIVAL, 8'h00, 16'h0001, pick_gap());
    send_request(REQ_TICK, 8'hFF, 16'hFFFF, pick_gap());
    send_request(REQ_TICK, 8'h00, 16'h0000, pick_gap());
    send_request(REQ_ARRIVAL, 8'h5A, 16'h0003, pick_gap());
    send_request(REQ_TICK, 8'hA5, 16'h5A5A, pick_gap());
    send_request(REQ_ARRIVAL, 8'hA5, 16'h0003, pick_gap());
    send_request(REQ_TICK, 8'h00, 16'h0000, pick_gap());
    send_request(REQ_ARRIVAL, 8'h33, 16'h0000, pick_gap());
    send_request(REQ_TICK, 8'h00, 16'h0000, pick_gap());
    // fill the queue with equal lengths, then one drop
    for (int i = 0; i < 13; i++) begin
      send_request(REQ_ARRIVAL, 8'h10 + i, 16'h0004, pick_gap());
    end
    send_request(REQ_ARRIVAL, 8'hEE, 16'h0002, pick_gap());
    drain_results();

    // random mix in phases of changing arrival pressure
    for (int n = 0; n < 425; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       arrive_pct = 25;
          1:       arrive_pct = 50;
          default: arrive_pct = 75;
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      if (n == 200) drain_results();
      kind = ($urandom_range(0, 99) < arrive_pct) ? REQ_ARRIVAL : REQ_TICK;
      send_request(kind, $urandom_range(0, 255), pick_duration(), steady ? 0 : pick_gap());
    end

    drain_results();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
